// File: hw/rtl/scanline_sprite_evaluation_core_defines.svh
// ----------------------------------------------------------------------------
// Scanline sprite evaluation assertion macros
// Shared concurrent assertion forms for the sprite evaluation RTL.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_SPRITE_EVALUATION_CORE_DEFINES_SVH
`define SCANLINE_SPRITE_EVALUATION_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sse assertion failed");

`endif

// File: hw/rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// Sprite evaluation package
// Sizes, codes and shared types of the scanline sprite evaluation core.
// ----------------------------------------------------------------------------
`default_nettype none

package sse_pkg;

	localparam int SPRITES = 64;
	localparam int SLOTS   = 8;

	localparam int IDX_W = (SPRITES > 1) ? $clog2(SPRITES) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int P_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic       ACT_WRITE = 1'b0;
	localparam logic       ACT_EVAL  = 1'b1;
	localparam logic [7:0] WIN_MAIN  = 8'h0F;
	localparam logic [7:0] WIN_SUB   = 8'hF0;
	localparam int         X_LIMIT   = 240;

	typedef struct packed {
		logic signed [10:0] x;
		logic signed [10:0] y;
		logic [7:0]         w;
		logic [7:0]         h;
		logic [7:0]         win;
		logic               en;
		logic               hi;
		logic               dbl;
	} sprite_t;

	localparam int ENTRY_W = $bits(sprite_t);

	typedef struct packed {
		logic             is_eval;
		logic [IDX_W-1:0] addr;
		sprite_t          entry;
		logic [7:0]       line;
	} cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/scanline_sprite_evaluation_core.sv
// A write request stores one sprite entry. An evaluate request reads the table RAM
// through its single read port at one entry per cycle, up to SPRITES entries (fewer
// when both lists fill), then emits 2*SLOTS slot results at one per cycle while
// out_ready is high. A two-entry command queue lets requests be taken while an
// evaluation runs. Reset clears the table at once through per-entry valid bits, so
// no clearing pass is needed.
// ----------------------------------------------------------------------------
// Scanline sprite evaluation core
// Top level joining the request front end and the evaluation back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_sprite_evaluation_core
	import sse_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [5:0]         sprite_slot,
	input  wire logic signed [10:0] pos_x,
	input  wire logic signed [10:0] pos_y,
	input  wire logic [7:0]         sprite_width,
	input  wire logic [7:0]         sprite_height,
	input  wire logic [7:0]         window_mask,
	input  wire logic               enabled,
	input  wire logic               high_priority,
	input  wire logic               double_size,
	input  wire logic [7:0]         scanline,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    list_select,
	output logic [2:0]              list_position,
	output logic                    occupied,
	output logic [5:0]              sprite_number,
	output logic                    last
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	sse_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.sprite_slot   (sprite_slot),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.sprite_width  (sprite_width),
		.sprite_height (sprite_height),
		.window_mask   (window_mask),
		.enabled       (enabled),
		.high_priority (high_priority),
		.double_size   (double_size),
		.scanline      (scanline),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	sse_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.list_select   (list_select),
		.list_position (list_position),
		.occupied      (occupied),
		.sprite_number (sprite_number),
		.last          (last)
	);

endmodule

`default_nettype wire

// File: hw/rtl/sse_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sse_front.sv
// ----------------------------------------------------------------------------
// Sprite evaluation front end
// Accepts requests, sorts writes from evaluations and queues the commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_front
	import sse_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [5:0]         sprite_slot,
	input  wire logic signed [10:0] pos_x,
	input  wire logic signed [10:0] pos_y,
	input  wire logic [7:0]         sprite_width,
	input  wire logic [7:0]         sprite_height,
	input  wire logic [7:0]         window_mask,
	input  wire logic               enabled,
	input  wire logic               high_priority,
	input  wire logic               double_size,
	input  wire logic [7:0]         scanline,
	output logic                    cmd_valid,
	input  wire logic               cmd_ready,
	output cmd_t                    cmd
);

	cmd_t       q_mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_in;
	logic       keep;
	logic       push;
	logic       pop;

	// Writes to slots beyond the table are dropped here.
	always_comb begin
		cmd_in.is_eval     = (action == ACT_EVAL);
		cmd_in.addr        = IDX_W'(sprite_slot);
		cmd_in.entry.x     = pos_x;
		cmd_in.entry.y     = pos_y;
		cmd_in.entry.w     = sprite_width;
		cmd_in.entry.h     = sprite_height;
		cmd_in.entry.win   = window_mask;
		cmd_in.entry.en    = enabled;
		cmd_in.entry.hi    = high_priority;
		cmd_in.entry.dbl   = double_size;
		cmd_in.line        = scanline;
		keep = cmd_in.is_eval || ({3'b000, sprite_slot} < 9'(SPRITES));
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rptr_q];
	assign push      = in_valid && in_ready && keep;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sse_back.sv
// ----------------------------------------------------------------------------
// Sprite evaluation back end
// Holds the sprite table, walks it for a scanline and emits the slot lists.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scanline_sprite_evaluation_core_defines.svh"

module sse_back
	import sse_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	output logic       cmd_ready,
	input  wire cmd_t  cmd,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic       list_select,
	output logic [2:0] list_position,
	output logic       occupied,
	output logic [5:0] sprite_number,
	output logic       last
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t               state_q;
	logic [SPRITES-1:0]   valid_q;
	logic [7:0]           line_q;
	logic [IDX_W:0]       issue_q;
	logic                 pend_s1;
	logic                 vbit_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [CNT_W-1:0]     fill_q [2];
	logic [CNT_W-1:0]     fill_nxt [2];
	logic [5:0]           list_q [2][SLOTS];
	logic                 emit_sel_q;
	logic [P_W-1:0]       emit_p_q;
	logic                 out_valid_q;
	logic                 out_sel_q;
	logic [2:0]           out_pos_q;
	logic                 out_occ_q;
	logic [5:0]           out_num_q;
	logic                 out_last_q;

	logic                 cmd_pop;
	logic                 ram_we;
	logic                 issue_go;
	logic [ENTRY_W-1:0]   ram_rdata;
	sprite_t              ent;
	logic [8:0]           h9;
	logic [8:0]           w9;
	logic signed [11:0]   x_w;
	logic signed [11:0]   y_w;
	logic signed [11:0]   line_w;
	logic signed [11:0]   top_lim;
	logic signed [11:0]   left_lim;
	logic                 covers;
	logic                 sel_l;
	logic                 hit;
	logic                 walk_done;
	logic                 out_load;
	logic                 emit_occ;
	logic                 emit_last;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_pop   = cmd_valid && cmd_ready;
	assign ram_we    = cmd_pop && !cmd.is_eval;

	sse_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SPRITES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.addr),
		.wdata (cmd.entry),
		.re    (issue_go),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		ent      = sprite_t'(ram_rdata);
		h9       = ent.dbl ? {ent.h, 1'b0} : {1'b0, ent.h};
		w9       = ent.dbl ? {ent.w, 1'b0} : {1'b0, ent.w};
		x_w      = {ent.x[10], ent.x};
		y_w      = {ent.y[10], ent.y};
		line_w   = {4'b0000, line_q};
		top_lim  = line_w - $signed({3'b000, h9});
		left_lim = -$signed({3'b000, w9});
		covers   = (y_w <= line_w) && (y_w > top_lim) &&
			(x_w < 12'(X_LIMIT)) && (x_w > left_lim) &&
			!(((ent.win & WIN_MAIN) == 8'h00) && ((ent.win & WIN_SUB) == 8'h00));
		sel_l    = ent.hi;
		hit      = pend_s1 && vbit_s1 && ent.en && covers &&
			(fill_q[sel_l] < CNT_W'(SLOTS));
		fill_nxt = fill_q;
		if (hit) begin
			fill_nxt[sel_l] = fill_q[sel_l] + CNT_W'(1);
		end
		walk_done = (state_q == ST_WALK) &&
			(((fill_nxt[0] >= CNT_W'(SLOTS)) && (fill_nxt[1] >= CNT_W'(SLOTS))) ||
			(issue_q == (IDX_W + 1)'(SPRITES)));
		issue_go = (state_q == ST_WALK) && !walk_done &&
			(issue_q < (IDX_W + 1)'(SPRITES));
	end

	always_comb begin
		out_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		emit_occ  = CNT_W'(emit_p_q) < fill_q[emit_sel_q];
		emit_last = emit_sel_q && (emit_p_q == P_W'(SLOTS - 1));
	end

	always_ff @(posedge clk) begin
		idx_s1  <= issue_q[IDX_W-1:0];
		vbit_s1 <= valid_q[issue_q[IDX_W-1:0]];
		if (cmd_pop && cmd.is_eval) begin
			line_q <= cmd.line;
		end
		if ((state_q == ST_WALK) && hit) begin
			list_q[sel_l][fill_q[sel_l][P_W-1:0]] <= 6'(idx_s1);
		end
		if (out_load) begin
			out_sel_q  <= emit_sel_q;
			out_pos_q  <= 3'(emit_p_q);
			out_occ_q  <= emit_occ;
			out_num_q  <= emit_occ ? list_q[emit_sel_q][emit_p_q] : 6'd0;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			issue_q     <= '0;
			pend_s1     <= 1'b0;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			emit_sel_q  <= 1'b0;
			emit_p_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ram_we) begin
						valid_q[cmd.addr] <= 1'b1;
					end
					if (cmd_pop && cmd.is_eval) begin
						fill_q[0] <= '0;
						fill_q[1] <= '0;
						issue_q   <= '0;
						pend_s1   <= 1'b0;
						state_q   <= ST_WALK;
					end
				end
				ST_WALK: begin
					fill_q <= fill_nxt;
					if (issue_go) begin
						issue_q <= issue_q + (IDX_W + 1)'(1);
					end
					pend_s1 <= issue_go;
					if (walk_done) begin
						emit_sel_q <= 1'b0;
						emit_p_q   <= '0;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (emit_p_q == P_W'(SLOTS - 1)) begin
							emit_p_q <= '0;
							if (emit_sel_q) begin
								state_q <= ST_IDLE;
							end else begin
								emit_sel_q <= 1'b1;
							end
						end else begin
							emit_p_q <= emit_p_q + P_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign list_select   = out_sel_q;
	assign list_position = out_pos_q;
	assign occupied      = out_occ_q;
	assign sprite_number = out_num_q;
	assign last          = out_last_q;

	`SSE_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1,
		(fill_q[0] <= CNT_W'(SLOTS)) && (fill_q[1] <= CNT_W'(SLOTS)))
	`SSE_ASSERT_NEXT(a_last_ends_emit, clk, arst_n, out_load && emit_last,
		state_q == ST_IDLE)
	`SSE_ASSERT_SAME(a_pend_in_walk, clk, arst_n, pend_s1, state_q == ST_WALK)

endmodule

`default_nettype wire

// File: tb/scanline_sprite_evaluation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline sprite evaluation checker
// Keeps a shadow of the sprite table from accepted write requests, works out
// the sixteen slot results of every accepted evaluate request and compares
// each accepted output slot, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module scanline_sprite_evaluation_checker
	import sse_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               action,
	input  logic [5:0]         sprite_slot,
	input  logic signed [10:0] pos_x,
	input  logic signed [10:0] pos_y,
	input  logic [7:0]         sprite_width,
	input  logic [7:0]         sprite_height,
	input  logic [7:0]         window_mask,
	input  logic               enabled,
	input  logic               high_priority,
	input  logic               double_size,
	input  logic [7:0]         scanline,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               list_select,
	input  logic [2:0]         list_position,
	input  logic               occupied,
	input  logic [5:0]         sprite_number,
	input  logic               last,
	output int                 mismatch_count,
	output int                 slots_pending
);

	localparam logic LIST_LOW  = 1'b0;
	localparam logic LIST_HIGH = 1'b1;

	typedef struct packed {
		logic       sel;
		logic [2:0] pos;
		logic       occ;
		logic [5:0] num;
		logic       lst;
	} slot_result_t;

	sprite_t      sprite_shadow [SPRITES];
	slot_result_t expected_slots [$];
	int           error_tally = 0;

	assign mismatch_count = error_tally;

	task automatic flag_error(input string msg);
		$display("[%0t] slot mismatch: %s", $time, msg);
		error_tally++;
	endtask

	function automatic bit sprite_on_line(input sprite_t s, input int line_no);
		int sx;
		int sy;
		int sw;
		int sh;
		sx = $signed(s.x);
		sy = $signed(s.y);
		sw = s.w;
		sh = s.h;
		if (s.dbl) begin
			sw = sw * 2;
			sh = sh * 2;
		end
		if ((s.win & WIN_MAIN) == 0 && (s.win & WIN_SUB) == 0)
			return 1'b0;
		return (sy <= line_no) && (sy > line_no - sh) && (sx < X_LIMIT) && (sx > -sw);
	endfunction

	function automatic void evaluate_line(input int line_no);
		int fill [2];
		int picked [2][SLOTS];
		int which;
		slot_result_t r;
		fill[0] = 0;
		fill[1] = 0;
		for (int i = 0; i < SPRITES; i++) begin
			if (!sprite_shadow[i].en)
				continue;
			which = sprite_shadow[i].hi ? 1 : 0;
			if (fill[which] >= SLOTS)
				continue;
			if (sprite_on_line(sprite_shadow[i], line_no)) begin
				picked[which][fill[which]] = i;
				fill[which]++;
				if (fill[0] >= SLOTS && fill[1] >= SLOTS)
					break;
			end
		end
		for (int l = 0; l < 2; l++) begin
			for (int p = 0; p < SLOTS; p++) begin
				r.sel = (l == 1) ? LIST_HIGH : LIST_LOW;
				r.pos = 3'(p);
				r.occ = (p < fill[l]);
				r.num = r.occ ? 6'(picked[l][p]) : 6'd0;
				r.lst = (l == 1) && (p == SLOTS - 1);
				expected_slots.push_back(r);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		slot_result_t want;
		sprite_t entry;
		if (!arst_n) begin
			foreach (sprite_shadow[i])
				sprite_shadow[i] = '0;
			expected_slots.delete();
			slots_pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_slots.size() == 0) begin
					flag_error($sformatf("result list %0d pos %0d arrived with none expected",
						list_select, list_position));
				end else begin
					want = expected_slots.pop_front();
					if (list_select !== want.sel)
						flag_error($sformatf("list_select expected %0d, got %0d",
							want.sel, list_select));
					if (list_position !== want.pos)
						flag_error($sformatf("list_position expected %0d, got %0d",
							want.pos, list_position));
					if (occupied !== want.occ)
						flag_error($sformatf("occupied at list %0d pos %0d expected %0d, got %0d",
							want.sel, want.pos, want.occ, occupied));
					if (sprite_number !== want.num)
						flag_error($sformatf("sprite_number at list %0d pos %0d expected %0d, got %0d",
							want.sel, want.pos, want.num, sprite_number));
					if (last !== want.lst)
						flag_error($sformatf("last at list %0d pos %0d expected %0d, got %0d",
							want.sel, want.pos, want.lst, last));
				end
			end
			if (in_valid && in_ready) begin
				if (action == ACT_WRITE) begin
					entry.x   = pos_x;
					entry.y   = pos_y;
					entry.w   = sprite_width;
					entry.h   = sprite_height;
					entry.win = window_mask;
					entry.en  = enabled;
					entry.hi  = high_priority;
					entry.dbl = double_size;
					if (sprite_slot < SPRITES)
						sprite_shadow[sprite_slot] = entry;
				end else begin
					evaluate_line(scanline);
				end
			end
			slots_pending <= expected_slots.size();
		end
	end

endmodule

// File: tb/tb_scanline_sprite_evaluation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline sprite evaluation core testbench
// Drives sprite writes and scanline evaluations through the request channel,
// first a directed set around list filling and coverage edges, then random
// rounds with bursty requests, a stalling receiver, a long output hold-off and
// drain pauses. A separate checker predicts and compares every slot result.
// ----------------------------------------------------------------------------
module tb_scanline_sprite_evaluation_core;
	import sse_pkg::*;

	localparam int ITEM_TARGET   = 330;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_TOGGLE} rx_mode_t;

	typedef struct {
		logic               act;
		logic [5:0]         slot;
		logic signed [10:0] x;
		logic signed [10:0] y;
		logic [7:0]         w;
		logic [7:0]         h;
		logic [7:0]         win;
		logic               en;
		logic               hi;
		logic               dbl;
		logic [7:0]         line;
	} sprite_req_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [5:0]         sprite_slot;
	logic signed [10:0] pos_x;
	logic signed [10:0] pos_y;
	logic [7:0]         sprite_width;
	logic [7:0]         sprite_height;
	logic [7:0]         window_mask;
	logic               enabled;
	logic               high_priority;
	logic               double_size;
	logic [7:0]         scanline;
	logic               out_valid;
	logic               out_ready;
	logic               list_select;
	logic [2:0]         list_position;
	logic               occupied;
	logic [5:0]         sprite_number;
	logic               last;

	int          mismatch_count;
	int          slots_pending;
	bit          long_hold_req = 1'b0;
	int unsigned cycle_count = 0;
	int          sent = 0;

	scanline_sprite_evaluation_core dut (
		.clk, .arst_n, .in_valid, .in_ready, .action, .sprite_slot, .pos_x, .pos_y,
		.sprite_width, .sprite_height, .window_mask, .enabled, .high_priority, .double_size,
		.scanline, .out_valid, .out_ready, .list_select, .list_position, .occupied,
		.sprite_number, .last
	);

	scanline_sprite_evaluation_checker slot_checker (
		.clk, .arst_n, .in_valid, .in_ready, .action, .sprite_slot, .pos_x, .pos_y,
		.sprite_width, .sprite_height, .window_mask, .enabled, .high_priority, .double_size,
		.scanline, .out_valid, .out_ready, .list_select, .list_position, .occupied,
		.sprite_number, .last, .mismatch_count, .slots_pending
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : receiver
		rx_mode_t mode;
		int span;
		out_ready = 1'b0;
		mode = RX_ALWAYS;
		span = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold_req = 1'b0;
			end else begin
				if (span == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					span = $urandom_range(8, 80);
				end
				span--;
				case (mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_HALF:   out_ready <= ($urandom_range(0, 99) < 50);
					RX_MOSTLY: out_ready <= ($urandom_range(0, 99) < 85);
					default:   out_ready <= ~out_ready;
				endcase
			end
		end
	end

	function automatic sprite_req_t sprite_write(input int slot, input int x, input int y,
			input int w, input int h, input logic [7:0] win, input bit en, input bit hi,
			input bit dbl);
		sprite_req_t r;
		r.act  = ACT_WRITE;
		r.slot = 6'(slot);
		r.x    = 11'(x);
		r.y    = 11'(y);
		r.w    = 8'(w);
		r.h    = 8'(h);
		r.win  = win;
		r.en   = en;
		r.hi   = hi;
		r.dbl  = dbl;
		r.line = 8'd0;
		return r;
	endfunction

	function automatic sprite_req_t line_eval(input int line_no);
		sprite_req_t r;
		r = sprite_write(0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0, 1'b0);
		r.act  = ACT_EVAL;
		r.line = 8'(line_no);
		return r;
	endfunction

	function automatic sprite_req_t noise_request();
		sprite_req_t r;
		r.act  = $urandom_range(0, 1) ? ACT_EVAL : ACT_WRITE;
		r.slot = 6'($urandom);
		r.x    = 11'($urandom);
		r.y    = 11'($urandom);
		r.w    = 8'($urandom);
		r.h    = 8'($urandom);
		r.win  = 8'($urandom);
		r.en   = 1'($urandom);
		r.hi   = 1'($urandom);
		r.dbl  = 1'($urandom);
		r.line = 8'($urandom);
		return r;
	endfunction

	function automatic logic [7:0] pick_extent();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return 8'($urandom_range(1, 48));
		else if (sel == 6)
			return 8'd0;
		else if (sel == 7)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic sprite_req_t random_write();
		sprite_req_t r;
		int sel;
		int span_w;
		r      = noise_request();
		r.act  = ACT_WRITE;
		r.en   = ($urandom_range(0, 99) < 85);
		r.hi   = 1'($urandom_range(0, 1));
		r.dbl  = ($urandom_range(0, 3) == 0);
		r.w    = pick_extent();
		r.h    = pick_extent();
		if ($urandom_range(0, 9) == 0)
			r.win = 8'h00;
		span_w = r.dbl ? 2 * int'(r.w) : int'(r.w);
		sel = $urandom_range(0, 9);
		if (sel < 7)
			r.x = 11'(int'($urandom_range(0, 300)) - 50);
		else if (sel == 7)
			r.x = 11'(X_LIMIT - 1 + int'($urandom_range(0, 1)));
		else if (sel == 8)
			r.x = 11'(-span_w + int'($urandom_range(0, 1)));
		sel = $urandom_range(0, 9);
		if (sel < 7)
			r.y = 11'(int'($urandom_range(0, 300)) - 40);
		else if (sel == 7)
			r.y = $urandom_range(0, 1) ? 11'sd0 : 11'sd255;
		return r;
	endfunction

	function automatic sprite_req_t random_eval();
		sprite_req_t r;
		r     = noise_request();
		r.act = ACT_EVAL;
		return r;
	endfunction

	task automatic send_request(input sprite_req_t r);
		@(negedge clk);
		action        <= r.act;
		sprite_slot   <= r.slot;
		pos_x         <= r.x;
		pos_y         <= r.y;
		sprite_width  <= r.w;
		sprite_height <= r.h;
		window_mask   <= r.win;
		enabled       <= r.en;
		high_priority <= r.hi;
		double_size   <= r.dbl;
		scanline      <= r.line;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (slots_pending != 0);
	endtask

	initial begin : stimulus
		sprite_req_t r;
		int burst_left;
		int round_no;
		int pick;
		bit gaps_on;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		action        = ACT_WRITE;
		sprite_slot   = '0;
		pos_x         = '0;
		pos_y         = '0;
		sprite_width  = '0;
		sprite_height = '0;
		window_mask   = '0;
		enabled       = 1'b0;
		high_priority = 1'b0;
		double_size   = 1'b0;
		scanline      = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Evaluation of the empty table after reset.
		send_request(line_eval(0));

		// Nine low and nine high candidates for line 128, so both lists overflow.
		for (int i = 0; i < 9; i++)
			send_request(sprite_write(i, (i == 0) ? -7 : ((i == 1) ? 239 : i * 25),
				(i == 2) ? 128 : ((i == 3) ? 89 : 100), 8, (i == 2) ? 1 : 40,
				(i < 8) ? (8'h01 << i) : 8'h80, 1'b1, 1'b0, (i == 4)));
		for (int i = 55; i < 64; i++)
			send_request(sprite_write(i, (i == 63) ? -509 : (i - 55) * 10, 64,
				(i == 63) ? 255 : 16, (i == 63) ? 255 : 33,
				(i[0]) ? 8'hF0 : 8'hFF, 1'b1, 1'b1, 1'b1));
		send_request(line_eval(128));

		// Right edge, disabled, no window and the coordinate extremes.
		send_request(sprite_write(0, 240, 100, 8, 40, 8'h0F, 1'b1, 1'b0, 1'b0));
		send_request(sprite_write(1, 10, 100, 8, 40, 8'h0F, 1'b0, 1'b0, 1'b0));
		send_request(sprite_write(2, 10, 100, 8, 40, 8'h00, 1'b1, 1'b0, 1'b0));
		send_request(sprite_write(3, -1024, -1024, 255, 255, 8'hFF, 1'b1, 1'b0, 1'b1));
		send_request(sprite_write(4, 1023, 1023, 255, 255, 8'hFF, 1'b1, 1'b0, 1'b1));
		send_request(line_eval(128));
		wait_for_results();

		round_no   = 0;
		burst_left = $urandom_range(1, 10);
		while (sent < ITEM_TARGET) begin
			gaps_on = ((round_no % 4) != 1) && (round_no != 2) && (round_no != 9);
			if (round_no == 2 || round_no == 9)
				long_hold_req = 1'b1;
			for (int k = 0; k < 24; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 62)
					r = random_write();
				else if (pick < 92)
					r = random_eval();
				else
					r = noise_request();
				send_request(r);
				if (gaps_on) begin
					burst_left--;
					if (burst_left <= 0) begin
						pause_sender(($urandom_range(0, 7) == 0) ?
							$urandom_range(20, 40) : $urandom_range(1, 6));
						burst_left = $urandom_range(1, 10);
					end
				end
			end
			if (round_no % 3 == 0)
				wait_for_results();
			round_no++;
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
